>>> src/sdfp_pkg.sv
// ----------------------------------------------------------------------------
// sdfp_pkg: shared definitions of the servo duty frame parser
// Frame byte codes, outcome codes and the record passed from the byte parser
// to the result stage.
// ----------------------------------------------------------------------------
package sdfp_pkg;

	localparam int FRAME_LENGTH = 8;
	localparam int POS_W        = $clog2(FRAME_LENGTH);
	localparam int QUEUE_DEPTH  = 2;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [7:0] HDR_FIRST  = 8'h4C; // 'L'
	localparam logic [7:0] HDR_SECOND = 8'h44; // 'D'
	localparam logic [7:0] HDR_TYPE   = 8'h02;
	localparam logic [7:0] HDR_SIGN   = 8'h2B; // '+'
	localparam logic [7:0] TRAILER    = 8'h23; // '#'

	// Byte positions inside a frame.
	localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SIGN   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_HIGH   = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LOW    = POS_W'(5);
	localparam logic [POS_W-1:0] POS_TRAIL  = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(FRAME_LENGTH - 1);

	typedef enum logic [0:0] {
		REG_LO_LIMIT = 1'b0,
		REG_HI_LIMIT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		OUT_APPLIED  = 2'd0,
		OUT_RANGE    = 2'd1,
		OUT_CHECKSUM = 2'd2
	} outcome_t;

	// One completed frame, as seen by the result stage.
	typedef struct packed {
		logic [15:0] duty;
		logic        csum_ok;
	} frame_rec_t;

endpackage

>>> src/sdfp_front.sv
// ----------------------------------------------------------------------------
// sdfp_front: byte parser
// Tracks the byte position, running XOR and duty bytes of the frame being
// received, and emits one record per check byte.
// ----------------------------------------------------------------------------
module sdfp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	output logic                  push,
	output sdfp_pkg::frame_rec_t  push_rec
);

	logic [sdfp_pkg::POS_W-1:0] position_q;
	logic [7:0]                 xor_q;
	logic [7:0]                 duty_high_q;
	logic [7:0]                 duty_low_q;
	logic                       match;
	logic                       at_check;

	assign at_check = (position_q == sdfp_pkg::POS_CHECK);

	always_comb begin
		unique case (position_q)
			sdfp_pkg::POS_FIRST:  match = (rx_byte == sdfp_pkg::HDR_FIRST);
			sdfp_pkg::POS_SECOND: match = (rx_byte == sdfp_pkg::HDR_SECOND);
			sdfp_pkg::POS_TYPE:   match = (rx_byte == sdfp_pkg::HDR_TYPE);
			sdfp_pkg::POS_SIGN:   match = (rx_byte == sdfp_pkg::HDR_SIGN);
			sdfp_pkg::POS_HIGH:   match = 1'b1;
			sdfp_pkg::POS_LOW:    match = 1'b1;
			sdfp_pkg::POS_TRAIL:  match = (rx_byte == sdfp_pkg::TRAILER);
			default:              match = 1'b0;
		endcase
	end

	assign push             = accept && at_check;
	assign push_rec.duty    = {duty_high_q, duty_low_q};
	assign push_rec.csum_ok = (rx_byte == xor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= sdfp_pkg::POS_FIRST;
			xor_q      <= 8'd0;
		end else if (accept) begin
			if (at_check) begin
				position_q <= sdfp_pkg::POS_FIRST;
				xor_q      <= 8'd0;
			end else if (match && position_q != sdfp_pkg::POS_FIRST) begin
				position_q <= position_q + sdfp_pkg::POS_W'(1);
				xor_q      <= xor_q ^ rx_byte;
			end else if (rx_byte == sdfp_pkg::HDR_FIRST) begin
				// An 'L' at the first position, or one that does not match its position, opens a new frame with a fresh checksum.
				position_q <= sdfp_pkg::POS_SECOND;
				xor_q      <= rx_byte;
			end else begin
				position_q <= sdfp_pkg::POS_FIRST;
				xor_q      <= 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_high_q <= 8'd0;
			duty_low_q  <= 8'd0;
		end else if (accept) begin
			if (position_q == sdfp_pkg::POS_HIGH)
				duty_high_q <= rx_byte;
			if (position_q == sdfp_pkg::POS_LOW)
				duty_low_q <= rx_byte;
		end
	end

endmodule

>>> src/sdfp_queue.sv
// ----------------------------------------------------------------------------
// sdfp_queue: frame record queue
// Small register FIFO that decouples the byte parser from the result stage.
// ----------------------------------------------------------------------------
module sdfp_queue #(
	parameter int DEPTH = sdfp_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sdfp_pkg::frame_rec_t  push_rec,
	input  logic                  pop,
	output sdfp_pkg::frame_rec_t  pop_rec,
	output logic                  not_empty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	sdfp_pkg::frame_rec_t entry_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign not_empty = (count_q != CNT_W'(0));
	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_rec   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> src/sdfp_back.sv
// ----------------------------------------------------------------------------
// sdfp_back: result stage
// Holds the duty limits, grades each frame record and presents the result
// in an output register.
// ----------------------------------------------------------------------------
module sdfp_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sdfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sdfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             rec_valid,
	input  sdfp_pkg::frame_rec_t             rec,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [15:0]                      duty,
	output logic [1:0]                       outcome
);

	logic [15:0]        lo_limit_q;
	logic [15:0]        hi_limit_q;
	logic               out_valid_q;
	logic [15:0]        duty_q;
	sdfp_pkg::outcome_t outcome_q;
	sdfp_pkg::outcome_t grade;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_limit_q <= 16'h0000;
			hi_limit_q <= 16'hFFFF;
		end else if (cfg_wr_en &&
		             cfg_index[sdfp_pkg::CFG_INDEX_W-1:1] == '0) begin
			unique case (sdfp_pkg::reg_index_t'(cfg_index[0]))
				sdfp_pkg::REG_LO_LIMIT: lo_limit_q <= cfg_data;
				sdfp_pkg::REG_HI_LIMIT: hi_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (!rec.csum_ok)
			grade = sdfp_pkg::OUT_CHECKSUM;
		else if (rec.duty >= lo_limit_q && rec.duty <= hi_limit_q)
			grade = sdfp_pkg::OUT_APPLIED;
		else
			grade = sdfp_pkg::OUT_RANGE;
	end

	assign pop = rec_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			duty_q    <= rec.duty;
			outcome_q <= grade;
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_q;
	assign outcome   = outcome_q;

endmodule

>>> src/servo_duty_frame_parser.sv
// ----------------------------------------------------------------------------
// servo_duty_frame_parser: servo duty command frame parser
// Recognizes 8-byte duty frames in a received byte stream and reports the
// duty and its outcome once per frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle unless in_stall is high
// because the queue is full. A byte parser tracks the frame position and
// running XOR per byte; on the check byte it pushes the assembled duty and
// checksum flag into a two-entry queue. A result stage grades the record
// against the lower and upper duty limits and holds the result in an output
// register, so a stalled result never holds up bytes until the queue is full.
// Write the lower limit (index 0) and the upper limit (index 1) only while no
// frame is in flight; other indexes are ignored.
module servo_duty_frame_parser #(
	parameter int QUEUE_DEPTH = sdfp_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sdfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sdfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [15:0]                      duty,
	output logic [1:0]                       outcome
);

	logic                 accept;
	logic                 push;
	logic                 pop;
	logic                 not_empty;
	logic                 full;
	sdfp_pkg::frame_rec_t push_rec;
	sdfp_pkg::frame_rec_t pop_rec;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	sdfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.push     (push),
		.push_rec (push_rec)
	);

	sdfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.pop_rec   (pop_rec),
		.not_empty (not_empty),
		.full      (full)
	);

	sdfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec_valid (not_empty),
		.rec       (pop_rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.duty      (duty),
		.outcome   (outcome)
	);

endmodule
